// ===== hdl/shtt_pkg.sv =====
// ----------------------------------------------------------------------------
// shtt_pkg
// Types and constants shared by the set-associative hash table modules.
// ----------------------------------------------------------------------------
package shtt_pkg;

	localparam int KeyW    = 64;
	localparam int DepthW  = 8;
	localparam int GenW    = 8;
	localparam int KindW   = 2;
	localparam int EvalW   = 16;
	localparam int MoveW   = 16;
	localparam int CmdW    = 2;
	localparam int Ways    = 4;
	localparam int WayIdxW = $clog2(Ways);
	localparam int AgeSh   = 2;
	localparam int ScW     = DepthW + GenW - 5 + AgeSh;
	localparam int QDepth  = 2;
	localparam int QPtrW   = $clog2(QDepth);

	localparam logic [CmdW-1:0] CMD_PROBE  = 2'd0;
	localparam logic [CmdW-1:0] CMD_STORE  = 2'd1;
	localparam logic [CmdW-1:0] CMD_NEWGEN = 2'd2;

	typedef enum logic {
		OP_PROBE,
		OP_STORE
	} op_e;

	typedef enum logic {
		BK_IDLE,
		BK_EVAL
	} bk_state_e;

	typedef struct packed {
		logic [CmdW-1:0]          command;
		logic [KeyW-1:0]          hash_key;
		logic [DepthW-1:0]        search_depth;
		logic [KindW-1:0]         node_kind;
		logic signed [EvalW-1:0]  score_value;
		logic [MoveW-1:0]         best_move;
	} req_t;

	typedef struct packed {
		logic                     hit;
		logic [DepthW-1:0]        found_depth;
		logic [GenW-1:0]          found_generation;
		logic [KindW-1:0]         found_kind;
		logic signed [EvalW-1:0]  found_score;
		logic [MoveW-1:0]         found_move;
	} rsp_t;

	typedef struct packed {
		op_e                      op;
		logic [KeyW-1:0]          key;
		logic [DepthW-1:0]        depth;
		logic [KindW-1:0]         kind;
		logic signed [EvalW-1:0]  eval;
		logic [MoveW-1:0]         move;
		logic [GenW-1:0]          gen;
	} q_item_t;

	typedef struct packed {
		logic [KeyW-1:0]          key;
		logic [DepthW-1:0]        depth;
		logic [GenW-1:0]          gen;
		logic [KindW-1:0]         kind;
		logic signed [EvalW-1:0]  eval;
		logic [MoveW-1:0]         move;
	} way_t;

	typedef way_t [Ways-1:0] row_t;

	typedef struct packed {
		logic clearing;
		logic eval_busy;
	} back_status_t;

endpackage

// ===== hdl/shtt_front.sv =====
// ----------------------------------------------------------------------------
// shtt_front
// Accepts request items, advances the generation and queues table work.
// ----------------------------------------------------------------------------
module shtt_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  shtt_pkg::req_t       req_item,
	output logic                 req_stall,
	input  logic                 q_full,
	input  logic                 clearing,
	output logic                 push,
	output shtt_pkg::q_item_t    push_item
);

	logic [shtt_pkg::GenW-1:0] gen_q;
	logic                      accept;

	assign req_stall = q_full | clearing;
	assign accept    = req_valid & ~req_stall;

	always_comb begin
		push_item.op    = (req_item.command == shtt_pkg::CMD_STORE) ?
			shtt_pkg::OP_STORE : shtt_pkg::OP_PROBE;
		push_item.key   = req_item.hash_key;
		push_item.depth = req_item.search_depth;
		push_item.kind  = req_item.node_kind;
		push_item.eval  = req_item.score_value;
		push_item.move  = req_item.best_move;
		push_item.gen   = gen_q;
		push = accept & ((req_item.command == shtt_pkg::CMD_PROBE) |
			(req_item.command == shtt_pkg::CMD_STORE));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= '0;
		end else if (accept && req_item.command == shtt_pkg::CMD_NEWGEN) begin
			gen_q <= gen_q + 1'b1;
		end
	end

endmodule

// ===== hdl/shtt_queue.sv =====
// ----------------------------------------------------------------------------
// shtt_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module shtt_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  shtt_pkg::q_item_t    push_item,
	output logic                 full,
	output logic                 head_valid,
	output shtt_pkg::q_item_t    head_item,
	input  logic                 pop
);

	shtt_pkg::q_item_t              entry_q [shtt_pkg::QDepth];
	logic [shtt_pkg::QPtrW-1:0]     wr_ptr_q;
	logic [shtt_pkg::QPtrW-1:0]     rd_ptr_q;
	logic [shtt_pkg::QPtrW:0]       cnt_q;
	logic                           do_push;
	logic                           do_pop;

	assign full       = (cnt_q == (shtt_pkg::QPtrW + 1)'(shtt_pkg::QDepth));
	assign head_valid = (cnt_q != '0);
	assign head_item  = entry_q[rd_ptr_q];
	assign do_push    = push & ~full;
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/shtt_back.sv =====
// ----------------------------------------------------------------------------
// shtt_back
// Cluster memory, clearing pass, way compare, replacement and result register.
// ----------------------------------------------------------------------------
module shtt_back #(
	parameter int CLUSTER_BITS = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  shtt_pkg::q_item_t        q_item,
	output logic                     q_pop,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output shtt_pkg::rsp_t           rsp_item,
	output shtt_pkg::back_status_t   status
);

	localparam int NumClusters = 1 << CLUSTER_BITS;

	shtt_pkg::row_t                   mem [NumClusters];
	shtt_pkg::row_t                   rd_q;
	shtt_pkg::row_t                   wr_row;
	shtt_pkg::row_t                   wr_data;
	shtt_pkg::way_t                   new_way;
	shtt_pkg::bk_state_e              state_q;
	shtt_pkg::bk_state_e              state_d;
	shtt_pkg::rsp_t                   rsp_q;
	shtt_pkg::rsp_t                   rsp_d;
	logic                             rsp_valid_q;
	logic                             rsp_load;
	logic                             clearing_q;
	logic [CLUSTER_BITS-1:0]          clr_idx_q;
	logic [CLUSTER_BITS-1:0]          cluster;
	logic [CLUSTER_BITS-1:0]          wr_addr;
	logic                             rd_en;
	logic                             wr_en;
	logic                             upd_en;
	logic                             hit_any;
	logic [shtt_pkg::WayIdxW-1:0]     hit_way;
	logic [shtt_pkg::WayIdxW-1:0]     victim;
	logic [shtt_pkg::WayIdxW-1:0]     sel_way;
	logic [shtt_pkg::GenW-1:0]        age [shtt_pkg::Ways];
	logic signed [shtt_pkg::ScW-1:0]  sc [shtt_pkg::Ways];
	logic signed [shtt_pkg::ScW-1:0]  worst;
	logic                             out_free;

	assign cluster   = q_item.key[shtt_pkg::KeyW-1 -: CLUSTER_BITS];
	assign out_free  = ~rsp_valid_q | ~rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;
	assign status.clearing  = clearing_q;
	assign status.eval_busy = (state_q == shtt_pkg::BK_EVAL);

	always_comb begin
		hit_any = 1'b0;
		hit_way = '0;
		for (int w = shtt_pkg::Ways - 1; w >= 0; w--) begin
			if (rd_q[w].key == q_item.key) begin
				hit_any = 1'b1;
				hit_way = shtt_pkg::WayIdxW'(w);
			end
		end
		for (int w = 0; w < shtt_pkg::Ways; w++) begin
			age[w] = q_item.gen - rd_q[w].gen;
			sc[w]  = $signed({{(shtt_pkg::ScW - shtt_pkg::DepthW){1'b0}}, rd_q[w].depth}) -
				$signed({1'b0, age[w], {shtt_pkg::AgeSh{1'b0}}});
		end
		victim = '0;
		worst  = sc[0];
		for (int w = 1; w < shtt_pkg::Ways; w++) begin
			if (sc[w] < worst) begin
				worst  = sc[w];
				victim = shtt_pkg::WayIdxW'(w);
			end
		end
	end

	always_comb begin
		new_way.key   = q_item.key;
		new_way.depth = q_item.depth;
		new_way.gen   = q_item.gen;
		new_way.kind  = q_item.kind;
		new_way.eval  = q_item.eval;
		new_way.move  = q_item.move;
		sel_way       = hit_any ? hit_way : victim;
		wr_row        = rd_q;
		wr_row[sel_way] = new_way;
		upd_en = ~hit_any | (q_item.depth >= rd_q[hit_way].depth);

		rsp_d.hit              = hit_any;
		rsp_d.found_depth      = hit_any ? rd_q[hit_way].depth : '0;
		rsp_d.found_generation = hit_any ? rd_q[hit_way].gen : '0;
		rsp_d.found_kind       = hit_any ? rd_q[hit_way].kind : '0;
		rsp_d.found_score      = hit_any ? rd_q[hit_way].eval : '0;
		rsp_d.found_move       = hit_any ? rd_q[hit_way].move : '0;
	end

	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		q_pop    = 1'b0;
		rsp_load = 1'b0;
		case (state_q)
			shtt_pkg::BK_IDLE: begin
				if (!clearing_q && q_valid) begin
					rd_en   = 1'b1;
					state_d = shtt_pkg::BK_EVAL;
				end
			end
			shtt_pkg::BK_EVAL: begin
				if (q_item.op == shtt_pkg::OP_STORE) begin
					wr_en   = upd_en;
					q_pop   = 1'b1;
					state_d = shtt_pkg::BK_IDLE;
				end else if (out_free) begin
					rsp_load = 1'b1;
					q_pop    = 1'b1;
					state_d  = shtt_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = shtt_pkg::BK_IDLE;
			end
		endcase
		wr_addr = clearing_q ? clr_idx_q : cluster;
		wr_data = clearing_q ? '0 : wr_row;
	end

	always_ff @(posedge clk) begin
		if (wr_en || clearing_q) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[cluster];
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= shtt_pkg::BK_IDLE;
			rsp_valid_q <= 1'b0;
			clearing_q  <= 1'b1;
			clr_idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == {CLUSTER_BITS{1'b1}}) begin
					clearing_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== hdl/set_assoc_hash_table_depth_age_replace.sv =====
// ----------------------------------------------------------------------------
// set_assoc_hash_table_depth_age_replace
// Four-way set-associative hash table with depth and age replacement.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid/req_stall/req_item: command 0 probes, 1 stores,
// 2 advances the generation. Probes return one item on rsp_valid/rsp_stall/
// rsp_item; stores and new-search commands return nothing.
// The front takes one request per cycle into a two-entry queue while there is
// room and no clearing pass runs; a new search is done in the front in that
// same cycle. The back works through one probe or store at a time: it reads
// the cluster row from the synchronous table memory, then compares the four
// ways and, for a store, writes the row back unless a matching way is deeper,
// or, for a probe, loads the result register; it pops that item before it
// reads the next cluster row. A probe's result passes through the queue entry,
// the row register and the result register. A stalled result is held in the
// output register; the back waits on a probe until the register is free, and
// the queue then fills and raises req_stall.
// After reset the table is cleared one cluster per cycle, all 2^CLUSTER_BITS
// clusters, with req_stall high; the generation starts at zero.
// ----------------------------------------------------------------------------
module set_assoc_hash_table_depth_age_replace #(
	parameter int CLUSTER_BITS = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  shtt_pkg::req_t    req_item,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output shtt_pkg::rsp_t    rsp_item
);

	logic                       push;
	shtt_pkg::q_item_t          push_item;
	logic                       q_full;
	logic                       q_valid;
	shtt_pkg::q_item_t          q_item;
	logic                       q_pop;
	shtt_pkg::back_status_t     status;

	shtt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_item  (req_item),
		.req_stall (req_stall),
		.q_full    (q_full),
		.clearing  (status.clearing),
		.push      (push),
		.push_item (push_item)
	);

	shtt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.head_valid (q_valid),
		.head_item  (q_item),
		.pop        (q_pop)
	);

	shtt_back #(
		.CLUSTER_BITS (CLUSTER_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item),
		.status    (status)
	);

	a_clear_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		status.clearing |-> req_stall)
		else $error("request taken during clearing pass");

	a_eval_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		status.eval_busy |-> q_valid)
		else $error("back evaluating with an empty queue");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_item.hit) |-> (rsp_item.found_depth == '0 &&
		rsp_item.found_generation == '0 && rsp_item.found_kind == '0 &&
		rsp_item.found_score == '0 && rsp_item.found_move == '0))
		else $error("miss result carries nonzero fields");

endmodule

// ===== sim/set_assoc_hash_table_depth_age_replace_tb.sv =====
// ----------------------------------------------------------------------------
// set_assoc_hash_table_depth_age_replace_tb
// Self-checking bench for the four-way depth/age hash table.
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a clocked driver. Each accepted request
// updates a shadow copy of the table and generation in the bench; each probe
// pushes the result it should return. A clocked monitor compares every
// returned item field by field with the oldest pending probe result.
// The run starts with directed cases: key zero on cleared ways, the all-ones
// key, the depth rule on a matching key, an unused command, and a full cluster
// forcing age-weighted replacement. Random phases follow, drawing keys mostly
// from a small pool of crowded clusters, with sender gaps, receiver stalls, a
// long receiver hold-off and a burst of new searches to wrap the generation.
// ----------------------------------------------------------------------------
module set_assoc_hash_table_depth_age_replace_tb;

	localparam int ClusterBits = 10;
	localparam int Clusters = 1 << ClusterBits;
	localparam logic [shtt_pkg::CmdW-1:0] CMD_NONE = 2'd3;
	localparam int ScoreCeil = 32'h7FFF_FFFF;
	localparam int AgeWeight = 4;
	localparam int KeyPoolSize = 40;
	localparam int PhaseItems = 58;
	localparam int GenBurst = 240;
	localparam int HoldCycles = 300;
	localparam int TailCycles = 20;
	localparam int WatchdogLimit = 6000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	shtt_pkg::req_t req_item = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	shtt_pkg::rsp_t rsp_item;

	shtt_pkg::req_t request_queue[$];
	shtt_pkg::rsp_t probe_results[$];
	shtt_pkg::rsp_t oldest_probe;

	shtt_pkg::way_t shadow_ways[Clusters][shtt_pkg::Ways];
	logic [shtt_pkg::GenW-1:0] shadow_gen;
	logic [shtt_pkg::KeyW-1:0] key_pool[KeyPoolSize];

	int send_idle_pct = 0;
	int stall_pct = 0;
	logic hold_arm = 1'b0;
	logic hold_done;
	int hold_left;
	int quiet_cycles;
	logic timed_out;
	int fail_count = 0;
	int n_probes = 0;
	int n_hits = 0;
	int n_stores = 0;
	int n_newgens = 0;
	int n_ignored = 0;

	set_assoc_hash_table_depth_age_replace #(
		.CLUSTER_BITS(ClusterBits)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_item(req_item),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_item(rsp_item)
	);

	always #4 clk = ~clk;

	function automatic shtt_pkg::req_t make_req(input logic [shtt_pkg::CmdW-1:0] cmd,
			input logic [shtt_pkg::KeyW-1:0] key,
			input logic [shtt_pkg::DepthW-1:0] depth = '0,
			input logic [shtt_pkg::KindW-1:0] kind = '0,
			input logic signed [shtt_pkg::EvalW-1:0] eval = '0,
			input logic [shtt_pkg::MoveW-1:0] move = '0);
		shtt_pkg::req_t rq;
		rq.command = cmd;
		rq.hash_key = key;
		rq.search_depth = depth;
		rq.node_kind = kind;
		rq.score_value = eval;
		rq.best_move = move;
		return rq;
	endfunction

	function automatic void apply_to_shadow(input shtt_pkg::req_t rq);
		int cl;
		int w;
		int match;
		int victim;
		int worst;
		int sc;
		logic keep;
		logic [shtt_pkg::GenW-1:0] age;
		shtt_pkg::rsp_t r;
		cl = int'(rq.hash_key >> (shtt_pkg::KeyW - ClusterBits));
		match = -1;
		for (w = shtt_pkg::Ways - 1; w >= 0; w--)
			if (shadow_ways[cl][w].key == rq.hash_key)
				match = w;
		case (rq.command)
			shtt_pkg::CMD_PROBE: begin
				r = '0;
				n_probes++;
				if (match >= 0) begin
					r.hit = 1'b1;
					r.found_depth = shadow_ways[cl][match].depth;
					r.found_generation = shadow_ways[cl][match].gen;
					r.found_kind = shadow_ways[cl][match].kind;
					r.found_score = shadow_ways[cl][match].eval;
					r.found_move = shadow_ways[cl][match].move;
					n_hits++;
				end
				probe_results.push_back(r);
			end
			shtt_pkg::CMD_STORE: begin
				n_stores++;
				if (match >= 0) begin
					victim = match;
					keep = rq.search_depth < shadow_ways[cl][match].depth;
				end else begin
					victim = 0;
					keep = 1'b0;
					worst = ScoreCeil;
					for (w = 0; w < shtt_pkg::Ways; w++) begin
						age = shadow_gen - shadow_ways[cl][w].gen;
						sc = int'(shadow_ways[cl][w].depth) - AgeWeight * int'(age);
						if (sc < worst) begin
							worst = sc;
							victim = w;
						end
					end
				end
				if (!keep)
					shadow_ways[cl][victim] = '{key: rq.hash_key, depth: rq.search_depth,
						gen: shadow_gen, kind: rq.node_kind, eval: rq.score_value,
						move: rq.best_move};
			end
			shtt_pkg::CMD_NEWGEN: begin
				n_newgens++;
				shadow_gen = shadow_gen + 1'b1;
			end
			default: n_ignored++;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_item <= '0;
		end else begin
			if (req_valid && !req_stall)
				apply_to_shadow(req_item);
			if (!req_valid || !req_stall) begin
				if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req_item <= request_queue.pop_front();
				end else
					req_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_arm && !hold_done) begin
			rsp_stall <= 1'b1;
			hold_left <= HoldCycles;
			hold_done <= 1'b1;
		end else
			rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (probe_results.size() == 0) begin
				$error("result item with no probe pending: hit %0d", rsp_item.hit);
				fail_count++;
			end else begin
				oldest_probe = probe_results.pop_front();
				if (rsp_item.hit !== oldest_probe.hit) begin
					$error("hit: expected %0d, got %0d", oldest_probe.hit, rsp_item.hit);
					fail_count++;
				end
				if (rsp_item.found_depth !== oldest_probe.found_depth) begin
					$error("found_depth: expected %0d, got %0d",
						oldest_probe.found_depth, rsp_item.found_depth);
					fail_count++;
				end
				if (rsp_item.found_generation !== oldest_probe.found_generation) begin
					$error("found_generation: expected %0d, got %0d",
						oldest_probe.found_generation, rsp_item.found_generation);
					fail_count++;
				end
				if (rsp_item.found_kind !== oldest_probe.found_kind) begin
					$error("found_kind: expected %0d, got %0d",
						oldest_probe.found_kind, rsp_item.found_kind);
					fail_count++;
				end
				if (rsp_item.found_score !== oldest_probe.found_score) begin
					$error("found_score: expected %0d, got %0d",
						oldest_probe.found_score, rsp_item.found_score);
					fail_count++;
				end
				if (rsp_item.found_move !== oldest_probe.found_move) begin
					$error("found_move: expected %0d, got %0d",
						oldest_probe.found_move, rsp_item.found_move);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else if (quiet_cycles < WatchdogLimit)
			quiet_cycles <= quiet_cycles + 1;
	end

	assign timed_out = quiet_cycles >= WatchdogLimit;

	task automatic wait_drained();
		while (!timed_out && (request_queue.size() != 0 || req_valid || probe_results.size() != 0))
			@(negedge clk);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_in, input int count);
		shtt_pkg::req_t rq;
		int i;
		int pick;
		send_idle_pct = idle_pct;
		stall_pct = stall_in;
		for (i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			rq.command = pick < 45 ? shtt_pkg::CMD_PROBE : pick < 85 ? shtt_pkg::CMD_STORE :
				pick < 95 ? shtt_pkg::CMD_NEWGEN : CMD_NONE;
			rq.hash_key = ($urandom_range(4) == 0) ? {$urandom, $urandom} :
				key_pool[$urandom_range(KeyPoolSize - 1)];
			rq.search_depth = ($urandom_range(1) == 0) ? 8'($urandom_range(15)) : 8'($urandom);
			rq.node_kind = 2'($urandom);
			rq.score_value = 16'($urandom);
			rq.best_move = 16'($urandom);
			request_queue.push_back(rq);
		end
		wait_drained();
	endtask

	initial begin
		logic [ClusterBits-1:0] hot[6];
		logic [shtt_pkg::KeyW-1:0] lane;
		int k;
		foreach (shadow_ways[c, w])
			shadow_ways[c][w] = '0;
		shadow_gen = '0;
		hot = '{10'h000, 10'h3FF, 10'h155, 10'h2AA, 10'($urandom), 10'($urandom)};
		key_pool[0] = '0;
		for (k = 1; k < KeyPoolSize; k++) begin
			key_pool[k] = {$urandom, $urandom};
			key_pool[k][shtt_pkg::KeyW-1 -: ClusterBits] = hot[k % 6];
		end
		lane = '0;
		lane[shtt_pkg::KeyW-1 -: ClusterBits] = 10'h155;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		request_queue.push_back(make_req(shtt_pkg::CMD_PROBE, '0));
		request_queue.push_back(make_req(shtt_pkg::CMD_PROBE, 64'h1));
		request_queue.push_back(make_req(shtt_pkg::CMD_STORE, '1, 8'hFF, 2'd3, 16'sh8000,
			16'hFFFF));
		request_queue.push_back(make_req(shtt_pkg::CMD_PROBE, '1));
		request_queue.push_back(make_req(shtt_pkg::CMD_STORE, '1, 8'h00, 2'd1, 16'sh0001,
			16'h0001));
		request_queue.push_back(make_req(shtt_pkg::CMD_PROBE, '1));
		request_queue.push_back(make_req(shtt_pkg::CMD_STORE, '1, 8'hFF, 2'd0, 16'sh7FFF,
			16'h0000));
		request_queue.push_back(make_req(shtt_pkg::CMD_PROBE, '1));
		request_queue.push_back(make_req(CMD_NONE, '1, 8'h01, 2'd2, 16'sh1234, 16'h5678));
		request_queue.push_back(make_req(shtt_pkg::CMD_PROBE, '1));
		request_queue.push_back(make_req(shtt_pkg::CMD_NEWGEN, '0));
		request_queue.push_back(make_req(shtt_pkg::CMD_STORE, lane | 64'd1, 8'd10, 2'd1,
			16'sh0100, 16'h0011));
		request_queue.push_back(make_req(shtt_pkg::CMD_STORE, lane | 64'd2, 8'd20, 2'd2,
			-16'sh0200, 16'h0022));
		request_queue.push_back(make_req(shtt_pkg::CMD_STORE, lane | 64'd3, 8'd5, 2'd3,
			16'sh0300, 16'h0033));
		request_queue.push_back(make_req(shtt_pkg::CMD_STORE, lane | 64'd4, 8'd30, 2'd0,
			-16'sh0400, 16'h0044));
		request_queue.push_back(make_req(shtt_pkg::CMD_NEWGEN, '0));
		request_queue.push_back(make_req(shtt_pkg::CMD_STORE, lane | 64'd5, 8'd7, 2'd2,
			16'sh0500, 16'h0055));
		request_queue.push_back(make_req(shtt_pkg::CMD_PROBE, lane | 64'd3));
		request_queue.push_back(make_req(shtt_pkg::CMD_PROBE, lane | 64'd5));
		request_queue.push_back(make_req(shtt_pkg::CMD_PROBE, lane | 64'd1));
		wait_drained();

		run_phase(0, 0, PhaseItems);
		run_phase(79, 0, PhaseItems);
		repeat (GenBurst)
			request_queue.push_back(make_req(shtt_pkg::CMD_NEWGEN, {$urandom, $urandom}));
		run_phase(0, 79, PhaseItems);
		run_phase(25, 25, PhaseItems);
		hold_arm = 1'b1;
		run_phase(0, 0, PhaseItems);

		repeat (TailCycles) @(negedge clk);
		if (probe_results.size() != 0) begin
			$error("%0d probe results never returned", probe_results.size());
			fail_count++;
		end
		$display("Sent %0d probes (%0d hits), %0d stores, %0d new searches, %0d unused commands",
			n_probes, n_hits, n_stores, n_newgens, n_ignored);
		$display("Final generation %0d; phases ran with sender gaps, receiver stalls and a hold-off",
			shadow_gen);
		if (!timed_out && fail_count == 0)
			$display("PASS set_assoc_hash_table_depth_age_replace");
		else
			$display("FAIL set_assoc_hash_table_depth_age_replace");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/shtt_pkg.sv
hdl/shtt_front.sv
hdl/shtt_queue.sv
hdl/shtt_back.sv
hdl/set_assoc_hash_table_depth_age_replace.sv
sim/set_assoc_hash_table_depth_age_replace_tb.sv
